// ----- hw/rtl/dq_pkg.sv -----
// Shared types and constants for the double-ended queue core.
// No dependencies; imported by dq_ram users and the top level.
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

    localparam int DQ_DEPTH  = 64;
    localparam int VALUE_W   = 32;
    localparam int CMD_W     = 3;
    localparam int IDX_W     = 6;
    localparam int CNT_OUT_W = 7;
    localparam int STATUS_W  = 2;

    localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_DELETE     = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_RD_FRONT,
        ST_RD_BACK,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

// ----- hw/rtl/double_ended_queue_core.sv -----
// Bounded double-ended queue of signed 32-bit words on a ring buffer in one RAM.
// Depends on dq_pkg and dq_ram.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one command word: push back,
//   push front, pop front, pop back, or delete at index. A word is taken at
//   a rising edge with i_valid high and o_stall low.
//   Output channel (o_valid / i_stall) returns one result word per command:
//   status, front and back word (-1 when empty), count and empty flag.
//   Result path: a taken command steps through read-front, read-back and
//   finish, then loads the result register; a delete that moves entries
//   first runs the shift state, one entry moved per cycle over the RAM's
//   single read and single write port. A new command, unused codes included,
//   is taken only once the last one is done, as the write / read-front /
//   read-back sequence uses the one RAM read port; deletes add their shift.
//   o_stall is high while a command is being worked on.
//   Receiver stall: the result register holds its word while i_stall is high;
//   a new command is still taken, and its work stops before the result
//   load until the register frees up.
//   Reset (synchronous, i_rst_n low) empties the queue: front pointer and
//   count go to zero. RAM contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_core
    import dq_pkg::*;
#(
    parameter int DEPTH = DQ_DEPTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // command channel
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [CMD_W-1:0]            i_command,
    input  wire logic signed [VALUE_W-1:0]   i_value,
    input  wire logic [IDX_W-1:0]            i_index,
    // result channel
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [STATUS_W-1:0]              o_status,
    output logic signed [VALUE_W-1:0]        o_front_value,
    output logic signed [VALUE_W-1:0]        o_back_value,
    output logic [CNT_OUT_W-1:0]             o_count,
    output logic                             o_is_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int CMP_W = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;

    // Ring position of (base + off), off at most DEPTH: one compare-subtract.
    function automatic logic [PTR_W-1:0] wrap(input logic [PTR_W-1:0] base,
                                              input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    // Control state
    t_state           r_state, n_state;
    logic [PTR_W-1:0] r_fp, n_fp;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_src, n_src;        // offset of the entry being moved
    t_status          r_status, n_status;
    logic [VALUE_W-1:0] r_front, n_front;

    // Result register
    logic                      r_out_valid;
    t_status                   r_out_status;
    logic signed [VALUE_W-1:0] r_out_front;
    logic signed [VALUE_W-1:0] r_out_back;
    logic [CNT_OUT_W-1:0]      r_out_count;
    logic                      r_out_empty;

    // RAM port signals
    logic               ram_wr_en;
    logic [PTR_W-1:0]   ram_wr_addr;
    logic [VALUE_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [PTR_W-1:0]   ram_rd_addr;
    logic [VALUE_W-1:0] ram_rd_data;

    logic accept;
    logic cnt_zero;
    logic full;
    logic [CMP_W-1:0] idx_c;
    logic [CMP_W-1:0] cnt_c;
    logic del_in_range;
    logic del_shift;
    logic shift_more;
    logic out_free;
    logic [PTR_W-1:0] fp_inc;
    logic [PTR_W-1:0] fp_dec;

    assign accept       = i_valid && (r_state == ST_IDLE);
    assign cnt_zero     = (r_count == '0);
    assign full         = (r_count == CNT_W'(DEPTH));
    assign idx_c        = CMP_W'(i_index);
    assign cnt_c        = CMP_W'(r_count);
    assign del_in_range = (idx_c < cnt_c);
    // Delete not at the front that has later entries to pull forward
    assign del_shift    = del_in_range && (idx_c != '0) && ((idx_c + CMP_W'(1)) < cnt_c);
    assign shift_more   = (SUM_W'(r_src) + SUM_W'(1)) < SUM_W'(r_count);
    assign out_free     = !r_out_valid || !i_stall;
    assign fp_inc       = (r_fp == PTR_W'(DEPTH - 1)) ? '0 : r_fp + PTR_W'(1);
    assign fp_dec       = (r_fp == '0) ? PTR_W'(DEPTH - 1) : r_fp - PTR_W'(1);

    dq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if ((t_cmd'(i_command) == CMD_DELETE) && del_shift) begin
                        n_state = ST_SHIFT;
                    end else begin
                        n_state = ST_RD_FRONT;
                    end
                end
            end
            ST_SHIFT: begin
                if (!shift_more) begin
                    n_state = ST_RD_FRONT;
                end
            end
            ST_RD_FRONT: n_state = ST_RD_BACK;
            ST_RD_BACK:  n_state = ST_FINISH;
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and RAM control
    always_comb begin
        n_fp        = r_fp;
        n_count     = r_count;
        n_src       = r_src;
        n_status    = r_status;
        n_front     = r_front;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_fp;
        ram_wr_data = i_value;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_fp;
        o_stall     = (r_state != ST_IDLE);

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_status = STAT_OK;
                    case (t_cmd'(i_command))
                        CMD_PUSH_BACK: begin
                            if (full) begin
                                n_status = STAT_FULL;
                            end else begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = wrap(r_fp, r_count);
                                n_count     = r_count + CNT_W'(1);
                            end
                        end
                        CMD_PUSH_FRONT: begin
                            if (full) begin
                                n_status = STAT_FULL;
                            end else begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = fp_dec;
                                n_fp        = fp_dec;
                                n_count     = r_count + CNT_W'(1);
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (cnt_zero) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                n_fp    = fp_inc;
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        CMD_POP_BACK: begin
                            if (cnt_zero) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        CMD_DELETE: begin
                            if (!del_in_range) begin
                                n_status = STAT_RANGE;
                            end else if (idx_c == '0) begin
                                // delete at the front is a pop front
                                n_fp    = fp_inc;
                                n_count = r_count - CNT_W'(1);
                            end else if (del_shift) begin
                                // fetch the entry after the gap; count drops after the shift
                                n_src       = CNT_W'(i_index) + CNT_W'(1);
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = wrap(r_fp, CNT_W'(i_index) + CNT_W'(1));
                            end else begin
                                // last entry: just drop it
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SHIFT: begin
                // move the fetched entry one place toward the front
                ram_wr_en   = 1'b1;
                ram_wr_addr = wrap(r_fp, r_src - CNT_W'(1));
                ram_wr_data = ram_rd_data;
                if (shift_more) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = wrap(r_fp, r_src + CNT_W'(1));
                    n_src       = r_src + CNT_W'(1);
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            ST_RD_FRONT: begin
                ram_rd_en   = !cnt_zero;
                ram_rd_addr = r_fp;
            end
            ST_RD_BACK: begin
                n_front     = ram_rd_data;
                ram_rd_en   = !cnt_zero;
                ram_rd_addr = wrap(r_fp, r_count - CNT_W'(1));
            end
            ST_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fp     <= '0;
            r_count  <= '0;
        end else begin
            r_state  <= n_state;
            r_fp     <= n_fp;
            r_count  <= n_count;
        end
    end

    // Working payload registers
    always_ff @(posedge i_clk) begin
        r_src    <= n_src;
        r_status <= n_status;
        r_front  <= n_front;
    end

    // Result register: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_FINISH) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FINISH) && out_free) begin
            r_out_status <= r_status;
            r_out_front  <= cnt_zero ? EMPTY_VALUE : r_front;
            r_out_back   <= cnt_zero ? EMPTY_VALUE : ram_rd_data;
            r_out_count  <= CNT_OUT_W'(r_count);
            r_out_empty  <= cnt_zero;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_front_value = r_out_front;
    assign o_back_value  = r_out_back;
    assign o_count       = r_out_count;
    assign o_is_empty    = r_out_empty;

endmodule

`default_nettype wire

// ----- hw/rtl/dq_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire
